// ----- rtl/bist_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bist_pkg
// Shared types, codes and sizes of the bounded integer set table.
// ----------------------------------------------------------------------------
package bist_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = 7;
  localparam int ROT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VAL_W = 32;

  localparam logic [CNT_W-1:0] INIT_CAP_RST = 7'd64;
  localparam logic [CNT_W-1:0] CAP_RST      = (DEPTH < 64) ? CNT_W'(DEPTH) : 7'd64;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_QUERY  = 3'd2,
    REQ_ADJUST = 3'd3,
    REQ_DUMP   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  localparam logic [3:0] STS_ADDED     = 4'd0;
  localparam logic [3:0] STS_PRESENT   = 4'd1;
  localparam logic [3:0] STS_FULL      = 4'd2;
  localparam logic [3:0] STS_REMOVED   = 4'd3;
  localparam logic [3:0] STS_NOT_FOUND = 4'd4;
  localparam logic [3:0] STS_MEMBER    = 4'd5;
  localparam logic [3:0] STS_ABSENT    = 4'd6;
  localparam logic [3:0] STS_ADJUSTED  = 4'd7;
  localparam logic [3:0] STS_ELEMENT   = 4'd8;
  localparam logic [3:0] STS_EMPTY     = 4'd9;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  // Token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                    active;
    cell_op_e                op;
    logic                    finished;
    logic                    found;
    logic                    deleting;
    logic [CNT_W-1:0]        left;
    logic signed [VAL_W-1:0] key;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_REPLY  = 2'd2,
    S_DUMP   = 2'd3
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/bist_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bist_cell
// One slot of the sorted row: holds a value, serves the passing token and
// takes its right neighbor's value on a shift.
// ----------------------------------------------------------------------------
module bist_cell
  import bist_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    shift,
  input  wire tok_t                    tok_in,
  input  wire logic signed [VAL_W-1:0] right_value,
  output tok_t                         tok_out,
  output logic signed [VAL_W-1:0]      value
);

  tok_t                    tok_next;
  logic signed [VAL_W-1:0] value_next;
  logic                    at_end;
  logic                    is_eq;
  logic                    is_gt;

  always_comb begin
    tok_next   = tok_in;
    value_next = value;
    at_end     = (tok_in.left == '0);
    is_eq      = (value == tok_in.key);
    is_gt      = (value > tok_in.key);
    if (!at_end) begin
      tok_next.left = tok_in.left - CNT_W'(1);
    end
    if (shift) begin
      value_next = right_value;
    end else if (tok_in.active && !tok_in.finished) begin
      case (tok_in.op)
        OP_SEARCH: begin
          if (at_end || is_gt) begin
            tok_next.finished = 1'b1;
          end else if (is_eq) begin
            tok_next.finished = 1'b1;
            tok_next.found    = 1'b1;
          end
        end
        OP_INSERT: begin
          // The row stays sorted: the larger value is bumped on to the right.
          if (at_end) begin
            value_next        = tok_in.key;
            tok_next.finished = 1'b1;
          end else if (is_eq) begin
            tok_next.finished = 1'b1;
            tok_next.found    = 1'b1;
          end else if (is_gt) begin
            value_next   = tok_in.key;
            tok_next.key = value;
          end
        end
        OP_REMOVE: begin
          if (tok_in.deleting) begin
            if (at_end) begin
              tok_next.finished = 1'b1;
            end else begin
              value_next = right_value;
            end
          end else if (at_end || is_gt) begin
            tok_next.finished = 1'b1;
          end else if (is_eq) begin
            value_next        = right_value;
            tok_next.deleting = 1'b1;
            tok_next.found    = 1'b1;
          end
        end
        default: begin
          tok_next.finished = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

// ----- rtl/bounded_integer_set_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_integer_set_table_unit
// Set of distinct signed integers kept sorted in a row of cells.
// ----------------------------------------------------------------------------
// The set lives in a row of DEPTH cells kept in ascending order, so a dump
// needs no sorting pass. Insert, remove and query send a token down the row,
// one cell per cycle, and answer once the token has left the last cell.
// Adjust and clear go straight to the reply. A dump rotates the whole row
// once, holding while the output stalls an element beat, and emits one
// element beat per stored value; a dump of an empty set only replies. One
// request is in work at a time; the next is taken once the last result is
// loaded into the output register, and after a dump only once the row has
// come full turn. Request types 6 and 7 are taken and give no result.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_unit
  import bist_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CNT_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2:0]              req_type,
  input  wire logic signed [VAL_W-1:0] item_value,
  input  wire logic signed [7:0]       capacity_delta,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [3:0]                   status,
  output logic signed [VAL_W-1:0]      out_value,
  output logic [CNT_W-1:0]             element_count,
  output logic [CNT_W-1:0]             set_capacity,
  output logic                         last
);

  state_e                  state;
  state_e                  state_next;
  req_e                    req_q;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        capacity;
  logic [CNT_W-1:0]        init_cap;
  logic [3:0]              reply_status;
  logic [ROT_W-1:0]        rot;
  tok_t                    launch;
  tok_t                    tok_chain [DEPTH+1];
  tok_t                    tail;
  logic signed [VAL_W-1:0] cell_value [DEPTH];

  logic             accept;
  logic             out_free;
  logic             shift;
  logic             emit;
  logic             reply_load;
  logic             rot_done;
  logic [7:0]       cap_up;
  logic [7:0]       dec_mag;
  logic [8:0]       cap_dn;
  logic [CNT_W-1:0] cap_adj;
  logic [CNT_W-1:0] cap_clr;

  assign cfg_ready    = 1'b1;
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign tok_chain[0] = launch;
  assign tail         = tok_chain[DEPTH];
  assign rot_done     = (rot == ROT_W'(DEPTH - 1));

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      bist_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .shift       (shift),
        .tok_in      (tok_chain[gi]),
        .right_value (cell_value[(gi + 1) % DEPTH]),
        .tok_out     (tok_chain[gi + 1]),
        .value       (cell_value[gi])
      );
    end
  endgenerate

  // New capacity for an adjust request and for a clear.
  always_comb begin
    cap_up  = {1'b0, capacity} + {1'b0, capacity_delta[6:0]};
    dec_mag = 8'(-capacity_delta);
    cap_dn  = {2'b00, capacity} - {1'b0, dec_mag};
    cap_adj = capacity;
    if (!capacity_delta[7] && (capacity_delta != 8'sd0)) begin
      cap_adj = (cap_up > 8'(DEPTH)) ? CNT_W'(DEPTH) : cap_up[CNT_W-1:0];
    end else if (capacity_delta[7]) begin
      cap_adj = (({1'b0, capacity} >= dec_mag) && (cap_dn[CNT_W-1:0] >= count))
                ? cap_dn[CNT_W-1:0] : count;
    end
    cap_clr = (init_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : init_cap;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_e'(req_type))
            REQ_INSERT, REQ_REMOVE, REQ_QUERY: state_next = S_SEARCH;
            REQ_ADJUST, REQ_CLEAR:             state_next = S_REPLY;
            REQ_DUMP: state_next = (count == '0) ? S_REPLY : S_DUMP;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (tail.active) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (shift && rot_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    shift      = 1'b0;
    emit       = 1'b0;
    reply_load = 1'b0;
    case (state)
      S_IDLE:  in_ready   = 1'b1;
      S_REPLY: reply_load = out_free;
      S_DUMP: begin
        // Stored values go out from cell 0; the rest of the turn is silent.
        if (CNT_W'(rot) < count) begin
          emit  = out_free;
          shift = out_free;
        end else begin
          shift = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CAP_RST;
      init_cap  <= INIT_CAP_RST;
      launch    <= '0;
      rot       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        init_cap <= cfg_data;
      end
      if (accept) begin
        launch.finished <= 1'b0;
        launch.found    <= 1'b0;
        launch.deleting <= 1'b0;
        launch.left     <= count;
        launch.key      <= item_value;
        rot             <= '0;
        case (req_e'(req_type))
          REQ_INSERT: begin
            launch.active <= 1'b1;
            launch.op     <= (count >= capacity) ? OP_SEARCH : OP_INSERT;
          end
          REQ_REMOVE: begin
            launch.active <= 1'b1;
            launch.op     <= OP_REMOVE;
          end
          REQ_QUERY: begin
            launch.active <= 1'b1;
            launch.op     <= OP_SEARCH;
          end
          REQ_ADJUST: begin
            launch.active <= 1'b0;
            capacity      <= cap_adj;
          end
          REQ_CLEAR: begin
            launch.active <= 1'b0;
            count         <= '0;
            capacity      <= cap_clr;
          end
          default: launch.active <= 1'b0;
        endcase
      end else begin
        launch.active <= 1'b0;
      end
      if ((state == S_SEARCH) && tail.active) begin
        case (req_q)
          REQ_REMOVE: begin
            if (tail.found) begin
              count    <= count - CNT_W'(1);
              capacity <= count - CNT_W'(1);
            end else begin
              capacity <= count;
            end
          end
          REQ_INSERT: begin
            if ((tail.op == OP_INSERT) && !tail.found) begin
              count <= count + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (shift) begin
        rot <= rot_done ? '0 : rot + ROT_W'(1);
      end
      if (emit || reply_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_e'(req_type);
      case (req_e'(req_type))
        REQ_ADJUST: reply_status <= STS_ADJUSTED;
        REQ_DUMP:   reply_status <= STS_EMPTY;
        REQ_CLEAR:  reply_status <= STS_EMPTY;
        default:    reply_status <= reply_status;
      endcase
    end else if ((state == S_SEARCH) && tail.active) begin
      case (req_q)
        REQ_REMOVE: reply_status <= tail.found ? STS_REMOVED : STS_NOT_FOUND;
        REQ_QUERY:  reply_status <= tail.found ? STS_MEMBER : STS_ABSENT;
        REQ_INSERT: begin
          if (tail.found) begin
            reply_status <= STS_PRESENT;
          end else begin
            reply_status <= (tail.op == OP_INSERT) ? STS_ADDED : STS_FULL;
          end
        end
        default: reply_status <= reply_status;
      endcase
    end
    if (emit) begin
      status        <= STS_ELEMENT;
      out_value     <= cell_value[0];
      element_count <= count;
      set_capacity  <= capacity;
      last          <= ((CNT_W'(rot) + CNT_W'(1)) == count);
    end else if (reply_load) begin
      status        <= reply_status;
      out_value     <= '0;
      element_count <= count;
      set_capacity  <= capacity;
      last          <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_within_cap : assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("element count exceeds capacity");

  a_cap_within_depth : assert property (@(posedge clk) disable iff (rst)
    capacity <= CNT_W'(DEPTH))
    else $error("capacity exceeds table depth");

  a_tail_only_in_search : assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == S_SEARCH))
    else $error("token left the row outside a search");

  a_search_gives_reply : assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEARCH) && tail.active) |=> (state == S_REPLY))
    else $error("finished search did not move to reply");
`endif

endmodule
`default_nettype wire
